>>> design/ibq_pkg.sv
// shared widths, register indexes and types for the int8 bias quantizer
`default_nettype none
package ibq_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned BiasW   = 17;
  localparam int unsigned DimW    = 11;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned SumW    = 57;
  localparam int unsigned SqW     = 2 * SampleW;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BIAS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DIM  = 1'b1;

  // int8 code limits
  localparam logic signed [CodeW-1:0] CODE_MAX = 8'sd127;
  localparam logic signed [CodeW-1:0] CODE_MIN = -8'sd128;

  // per-element result of the squared norm unit
  typedef struct packed {
    logic            last;
    logic [SumW-1:0] sum_half;
  } sq_res_t;

endpackage
`default_nettype wire

>>> design/ibq_quant.sv
// bias add, round half away from zero and clamp to int8
`default_nettype none
module ibq_quant (
  input  wire logic signed [ibq_pkg::SampleW-1:0] sample_i,
  input  wire logic signed [ibq_pkg::BiasW-1:0]   bias_i,
  output logic signed [ibq_pkg::CodeW-1:0]        code_o
);

  // q8 sum needs sample width plus two bits
  localparam int unsigned XW = ibq_pkg::SampleW + 2;

  logic signed [XW-1:0] x;
  logic [XW-1:0]        mag;
  logic [XW:0]          rsum;
  logic [XW-8:0]        rmag;
  logic [ibq_pkg::CodeW-1:0] r8;

  assign x = $signed({{2{sample_i[ibq_pkg::SampleW-1]}}, sample_i})
           + $signed({bias_i[ibq_pkg::BiasW-1], bias_i, 8'h00});

  // magnitude, the most negative value wraps to its unsigned magnitude
  assign mag  = x[XW-1] ? XW'(-x) : XW'(x);
  assign rsum = (XW+1)'(mag) + (XW+1)'(128);
  assign rmag = rsum[XW:8];
  assign r8   = rmag[ibq_pkg::CodeW-1:0];

  always_comb begin
    if (x[XW-1]) begin
      if (rmag > (XW-7)'(128)) begin
        code_o = ibq_pkg::CODE_MIN;
      end else begin
        code_o = $signed(ibq_pkg::CodeW'(8'd0 - r8));
      end
    end else begin
      if (rmag > (XW-7)'(127)) begin
        code_o = ibq_pkg::CODE_MAX;
      end else begin
        code_o = $signed(r8);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/ibq_sqacc.sv
// squared norm accumulator and element counter for one vector
`default_nettype none
module ibq_sqacc #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic signed [ibq_pkg::SampleW-1:0] sample_i,
  input  wire logic [ibq_pkg::DimW-1:0]           dimension_i,
  output ibq_pkg::sq_res_t                        res_o
);

  localparam int unsigned IdxW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CntW = $clog2(MAX_DIM + 1);
  localparam int unsigned CmpW = (CntW > ibq_pkg::DimW) ? CntW : ibq_pkg::DimW;
  localparam int unsigned AbsW = ibq_pkg::SampleW;
  localparam int unsigned SumW = ibq_pkg::SumW;

  logic [SumW-1:0] acc_q, acc_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic [AbsW-1:0]          abs_s;
  logic [ibq_pkg::SqW-1:0]  sq;
  logic [SumW:0]            acc_sum;
  logic [SumW-1:0]          acc_sat;
  logic [CmpW-1:0]          dim_ext;
  logic [CmpW-1:0]          eff_dim;
  logic [CmpW-1:0]          idx_inc;
  logic                     last;

  assign abs_s = sample_i[AbsW-1] ? AbsW'(-sample_i) : AbsW'(sample_i);
  assign sq    = ibq_pkg::SqW'(abs_s) * ibq_pkg::SqW'(abs_s);

  // saturate, only reachable at large MAX_DIM
  assign acc_sum = (SumW+1)'(acc_q) + (SumW+1)'(sq);
  assign acc_sat = acc_sum[SumW] ? {SumW{1'b1}} : acc_sum[SumW-1:0];

  // zero acts as one, oversize acts as MAX_DIM
  assign dim_ext = CmpW'(dimension_i);
  always_comb begin
    if (dim_ext == '0) begin
      eff_dim = CmpW'(1);
    end else if (dim_ext > CmpW'(MAX_DIM)) begin
      eff_dim = CmpW'(MAX_DIM);
    end else begin
      eff_dim = dim_ext;
    end
  end

  assign idx_inc = CmpW'(idx_q) + CmpW'(1);
  assign last    = (idx_inc >= eff_dim);

  assign res_o.last     = last;
  assign res_o.sum_half = last ? acc_sat : '0;

  always_comb begin
    acc_d = acc_q;
    idx_d = idx_q;
    if (step_i) begin
      if (last) begin
        acc_d = '0;
        idx_d = '0;
      end else begin
        acc_d = acc_sat;
        idx_d = idx_inc[IdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      idx_q <= '0;
    end else begin
      acc_q <= acc_d;
      idx_q <= idx_d;
    end
  end

endmodule
`default_nettype wire

>>> design/int8_bias_quantizer_sqnorm_top.sv
// top level of the int8 bias quantizer with half squared norm per vector
// one beat in, one beat out: each sample is registered, then combinational
// logic adds the bias, rounds half away from zero and clamps to int8, while a
// 24x24 squarer feeds a 57-bit running sum; the result lands in an output
// register. one beat is taken every cycle when the output side does not
// stall; the rate is set by the combinational square and accumulate. the beat
// that completes a vector (dimension elements, zero read as one, values above
// MAX_DIM read as MAX_DIM) carries last high and half the sum of squares with
// 17 fraction bits, then the sum and element count clear. half_sqnorm_o is
// zero on other beats. bias and dimension are written through the plain write
// port; the user must write them only while the block is idle, the block
// itself does not enforce it.
`default_nettype none
module int8_bias_quantizer_sqnorm_top #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [ibq_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [ibq_pkg::BiasW-1:0]          cfg_data_i,
  // input channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [ibq_pkg::SampleW-1:0] sample_i,
  // output channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [ibq_pkg::CodeW-1:0]        code_o,
  output logic                                    last_o,
  output logic [ibq_pkg::SumW-1:0]                half_sqnorm_o
);

  // configuration registers
  logic signed [ibq_pkg::BiasW-1:0] bias_q;
  logic [ibq_pkg::DimW-1:0]         dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q <= '0;
      dim_q  <= ibq_pkg::DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ibq_pkg::CFG_BIAS: bias_q <= $signed(cfg_data_i);
        ibq_pkg::CFG_DIM:  dim_q  <= cfg_data_i[ibq_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: the output register frees up when empty or drained,
  // the input register moves forward whenever the output register frees up
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic s1_move;
  logic in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !out_free;

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
    end
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input sample register
  logic signed [ibq_pkg::SampleW-1:0] sample_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
    end
  end

  // quantizer and squared norm on the registered sample
  logic signed [ibq_pkg::CodeW-1:0] code_c;
  ibq_pkg::sq_res_t                 sq_res;

  ibq_quant u_quant (
    .sample_i (sample_q),
    .bias_i   (bias_q),
    .code_o   (code_c)
  );

  ibq_sqacc #(
    .MAX_DIM (MAX_DIM)
  ) u_sqacc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s1_move),
    .sample_i    (sample_q),
    .dimension_i (dim_q),
    .res_o       (sq_res)
  );

  // result register, holds while the output side stalls
  logic signed [ibq_pkg::CodeW-1:0] code_q;
  logic                             last_q;
  logic [ibq_pkg::SumW-1:0]         sum_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      code_q <= code_c;
      last_q <= sq_res.last;
      sum_q  <= sq_res.sum_half;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_o        = code_q;
  assign last_o        = last_q;
  assign half_sqnorm_o = sum_q;

endmodule
`default_nettype wire
